### hdl/qn_pkg.sv
`default_nettype none
package qn_pkg;
	localparam int unsigned COMP_W = 32;
	localparam int unsigned MAG_W = 33;
	localparam int unsigned SUM_W = 65;
	localparam int unsigned ROOT_STAGES = 33;
	localparam int unsigned DIV_STAGES = 32;
	localparam logic [COMP_W-1:0] ONE_Q30 = 32'h4000_0000;

	typedef struct packed {
		logic              valid;
		logic              zero;
		logic [3:0]        neg;
		logic [MAG_W-1:0]  mag;
	} qn_ctl_t;
endpackage
`default_nettype wire

### hdl/qn_sqrt.sv
`default_nettype none
// Pipelined rounded square root: one result bit per stage.
module qn_sqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid,
	input  wire logic [qn_pkg::SUM_W-1:0]   sum,
	output logic                            root_valid,
	output logic [qn_pkg::MAG_W-1:0]        root
);
	localparam int unsigned N = qn_pkg::ROOT_STAGES;
	localparam int unsigned RW = N + 2;

	logic [N:1]                 v_s;
	logic [2*N-1:0]             x_s [1:N];
	logic [RW-1:0]              rem_s [1:N];
	logic [N-1:0]               r_s [1:N];

	for (genvar i = 0; i < N; i++) begin : g_st
		logic           v_c;
		logic [2*N-1:0] x_c;
		logic [RW-1:0]  rem_c;
		logic [N-1:0]   r_c;
		logic [RW-1:0]  rem_n;
		logic [RW-1:0]  trial;
		if (i == 0) begin : g_in
			always_comb begin
				v_c = valid;
				x_c = {1'b0, sum};
				rem_c = '0;
				r_c = '0;
			end
		end else begin : g_mid
			always_comb begin
				v_c = v_s[i];
				x_c = x_s[i];
				rem_c = rem_s[i];
				r_c = r_s[i];
			end
		end
		always_comb begin
			rem_n = {rem_c[RW-3:0], x_c[2*N-1 -: 2]};
			trial = rem_n - {r_c, 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_c;
			end
		end
		always_ff @(posedge clk) begin
			x_s[i+1] <= {x_c[2*N-3:0], 2'b00};
			if (!trial[RW-1]) begin
				rem_s[i+1] <= trial;
				r_s[i+1] <= {r_c[N-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= rem_n;
				r_s[i+1] <= {r_c[N-2:0], 1'b0};
			end
		end
	end

	// round up when rem > r
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_valid <= 1'b0;
		end else begin
			root_valid <= v_s[N];
		end
	end
	always_ff @(posedge clk) begin
		root <= (rem_s[N] > {2'b00, r_s[N]}) ? (r_s[N] + 1'b1) : r_s[N];
	end
endmodule
`default_nettype wire

### hdl/qn_div.sv
`default_nettype none
// One lane: q = round(mag * 2^30 / m), restoring, one bit per stage.
module qn_div (
	input  wire logic                       clk,
	input  wire logic [qn_pkg::COMP_W-1:0]  mag,
	input  wire logic [qn_pkg::MAG_W-1:0]   div,
	output logic [qn_pkg::COMP_W-1:0]       quo
);
	localparam int unsigned N = qn_pkg::DIV_STAGES;
	localparam int unsigned W = qn_pkg::MAG_W + 1;

	logic [W-1:0]               rem_s [1:N];
	logic [qn_pkg::MAG_W-1:0]   d_s [1:N];
	logic [N-1:0]               q_s [1:N];
	logic [N:0]                 q_inc;

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [qn_pkg::MAG_W-1:0] d_c;
		logic [N-1:0]             q_c;
		logic [W-1:0]             sh;
		logic [W:0]               t;
		if (i == 0) begin : g_in
			// leading step without shift gives the integer bit
			always_comb begin
				sh = {2'b00, mag};
				d_c = div;
				q_c = '0;
			end
		end else begin : g_mid
			always_comb begin
				sh = {rem_s[i][W-2:0], 1'b0};
				d_c = d_s[i];
				q_c = q_s[i];
			end
		end
		always_comb t = {1'b0, sh} - {2'b00, d_c};
		always_ff @(posedge clk) begin
			d_s[i+1] <= d_c;
			if (!t[W]) begin
				rem_s[i+1] <= t[W-1:0];
				q_s[i+1] <= {q_c[N-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= sh;
				q_s[i+1] <= {q_c[N-2:0], 1'b0};
			end
		end
	end

	// quotient carries one extra bit; add half and drop it
	always_comb q_inc = {1'b0, q_s[N]} + (N+1)'(1);
	always_ff @(posedge clk) begin
		quo <= q_inc[N:1];
	end
endmodule
`default_nettype wire

### hdl/quaternion_normalize.sv
`default_nettype none
// channel | ports                                   | beat
// in      | start, busy, scalar_in, vec_x/y/z_in     | start & !busy
// out     | done, scalar_out, vec_x/y/z_out, magnitude, zero_length | done
// One item per cycle; busy is always low. done and the results follow the
// accepting edge through 3 + 33 + 1 + 32 + 1 + 1 register stages.
// The root pipeline and four divider lanes set the latency.
// Reset clears the valid and control pipeline; the receiver cannot stall.
module quaternion_normalize (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire logic [31:0]  scalar_in,
	input  wire logic [31:0]  vec_x_in,
	input  wire logic [31:0]  vec_y_in,
	input  wire logic [31:0]  vec_z_in,
	output logic              done,
	output logic [31:0]       scalar_out,
	output logic [31:0]       vec_x_out,
	output logic [31:0]       vec_y_out,
	output logic [31:0]       vec_z_out,
	output logic [32:0]       magnitude,
	output logic              zero_length
);
	localparam int unsigned RL = qn_pkg::ROOT_STAGES + 1;
	localparam int unsigned DL = qn_pkg::DIV_STAGES + 1;

	logic [31:0] in_w [4];
	logic [31:0] mag_s1 [4];
	logic [3:0]  neg_s1;
	logic [63:0] sq_s2 [4];
	logic [3:0]  neg_s2;
	logic [64:0] sum_s3;
	logic [3:0]  neg_s3;
	logic [2:0]  v_q;

	assign busy = 1'b0;
	assign in_w[0] = scalar_in;
	assign in_w[1] = vec_x_in;
	assign in_w[2] = vec_y_in;
	assign in_w[3] = vec_z_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[1:0], start};
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_sq
		always_ff @(posedge clk) begin
			mag_s1[l] <= in_w[l][31] ? 32'(-in_w[l]) : in_w[l];
			neg_s1[l] <= in_w[l][31];
			sq_s2[l] <= mag_s1[l] * mag_s1[l];
			neg_s2[l] <= neg_s1[l];
			neg_s3[l] <= neg_s2[l];
		end
	end
	always_ff @(posedge clk) begin
		sum_s3 <= 65'(sq_s2[0]) + 65'(sq_s2[1]) + 65'(sq_s2[2]) + 65'(sq_s2[3]);
	end

	// magnitudes delayed alongside the root
	logic [31:0] mag_d [RL+2][4];
	logic [3:0]  neg_d [1:RL];
	for (genvar l = 0; l < 4; l++) begin : g_md
		always_ff @(posedge clk) begin
			mag_d[0][l] <= mag_s1[l];
			mag_d[1][l] <= mag_d[0][l];
		end
		for (genvar k = 2; k < RL + 2; k++) begin : g_k
			always_ff @(posedge clk) mag_d[k][l] <= mag_d[k-1][l];
		end
	end
	always_ff @(posedge clk) neg_d[1] <= neg_s3;
	for (genvar k = 2; k <= RL; k++) begin : g_nd
		always_ff @(posedge clk) neg_d[k] <= neg_d[k-1];
	end

	logic        rv;
	logic [32:0] root;
	qn_sqrt u_sqrt (.clk, .arst_n, .valid(v_q[2]), .sum(sum_s3), .root_valid(rv), .root);

	logic [31:0] quo [4];
	for (genvar l = 0; l < 4; l++) begin : g_lane
		qn_div u_div (.clk, .mag(mag_d[RL+1][l]), .div(root), .quo(quo[l]));
	end

	qn_pkg::qn_ctl_t ctl_in;
	qn_pkg::qn_ctl_t ctl_d [1:DL];
	always_comb begin
		ctl_in.valid = rv;
		ctl_in.zero = (root == '0);
		ctl_in.neg = neg_d[RL];
		ctl_in.mag = root;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_d[1] <= '0;
		end else begin
			ctl_d[1] <= ctl_in;
		end
	end
	for (genvar k = 2; k <= DL; k++) begin : g_cd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_d[k] <= '0;
			end else begin
				ctl_d[k] <= ctl_d[k-1];
			end
		end
	end

	// merge stage
	logic [31:0] res [4];
	for (genvar l = 0; l < 4; l++) begin : g_mg
		always_comb begin
			if (ctl_d[DL].zero) begin
				res[l] = (l == 0) ? qn_pkg::ONE_Q30 : '0;
			end else begin
				res[l] = ctl_d[DL].neg[l] ? 32'(-quo[l]) : quo[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_d[DL].valid;
		end
	end
	always_ff @(posedge clk) begin
		scalar_out <= res[0];
		vec_x_out <= res[1];
		vec_y_out <= res[2];
		vec_z_out <= res[3];
		magnitude <= ctl_d[DL].mag;
		zero_length <= ctl_d[DL].zero;
	end
endmodule
`default_nettype wire

### tb/quaternion_normalize_tb.sv
`default_nettype none
module quaternion_normalize_tb;
	localparam int LATENCY = 3 + qn_pkg::ROOT_STAGES + 1 + qn_pkg::DIV_STAGES + 2;

	typedef struct {
		logic [qn_pkg::COMP_W-1:0] q [4];
	} quat_t;

	typedef struct {
		logic [qn_pkg::COMP_W-1:0] part [4];
		logic [qn_pkg::MAG_W-1:0]  mag;
		logic                      zero;
	} unit_quat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [31:0]       scalar_in = '0;
	logic [31:0]       vec_x_in = '0;
	logic [31:0]       vec_y_in = '0;
	logic [31:0]       vec_z_in = '0;
	logic              done;
	logic [31:0]       scalar_out;
	logic [31:0]       vec_x_out;
	logic [31:0]       vec_y_out;
	logic [31:0]       vec_z_out;
	logic [32:0]       magnitude;
	logic              zero_length;

	quat_t      pending_quats [$];
	unit_quat_t expected_units [$];
	int         mismatches = 0;
	bit         stimulus_done = 1'b0;
	int         gap_left = 0;

	quaternion_normalize uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.scalar_in(scalar_in), .vec_x_in(vec_x_in), .vec_y_in(vec_y_in),
		.vec_z_in(vec_z_in), .done(done), .scalar_out(scalar_out),
		.vec_x_out(vec_x_out), .vec_y_out(vec_y_out), .vec_z_out(vec_z_out),
		.magnitude(magnitude), .zero_length(zero_length)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic unit_quat_t normalize_quat(quat_t x);
		unit_quat_t u;
		logic [31:0]  a [4];
		logic [64:0]  sum_sq;
		logic [64:0]  rem;
		logic [32:0]  root;
		logic [32:0]  m;
		logic [64:0]  num;
		logic [64:0]  quo;
		sum_sq = '0;
		for (int i = 0; i < 4; i++) begin
			a[i] = x.q[i][31] ? -x.q[i] : x.q[i];
			sum_sq += 65'(a[i]) * 65'(a[i]);
		end
		u.zero = (sum_sq == 0);
		if (u.zero) begin
			u.part[0] = qn_pkg::ONE_Q30;
			u.part[1] = '0;
			u.part[2] = '0;
			u.part[3] = '0;
			u.mag = '0;
			return u;
		end
		root = '0;
		for (int b = 32; b >= 0; b--) begin
			logic [32:0] t;
			t = root | (33'd1 << b);
			if (66'(t) * 66'(t) <= 66'(sum_sq))
				root = t;
		end
		rem = sum_sq - 65'(root) * 65'(root);
		m = (rem > 65'(root)) ? root + 1 : root;
		u.mag = m;
		for (int i = 0; i < 4; i++) begin
			num = (65'(a[i]) << 31) + 65'(m);
			quo = num / (65'(m) << 1);
			u.part[i] = x.q[i][31] ? -quo[31:0] : quo[31:0];
		end
		return u;
	endfunction

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7fff_ffff - $urandom_range(0, 3);
			2: return $urandom_range(0, 7) - 4;
			3: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		quat_t x;
		logic [31:0] corner [6] = '{32'h0, 32'h8000_0000, 32'h7fff_ffff,
			32'h1000_0000, 32'hf000_0000, 32'h1};
		for (int c = 0; c < 6; c++) begin
			for (int i = 0; i < 4; i++) x.q[i] = corner[c];
			pending_quats.push_back(x);
		end
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 4; i++) x.q[i] = '0;
			x.q[k] = 32'h1000_0000;
			pending_quats.push_back(x);
			x.q[k] = 32'h8000_0000;
			pending_quats.push_back(x);
			x.q[k] = 32'hffff_ffff;
			pending_quats.push_back(x);
		end
		for (int n = 0; n < 1750; n++) begin
			for (int i = 0; i < 4; i++) x.q[i] = rand_comp();
			if ($urandom_range(0, 9) == 0) x.q[$urandom_range(0, 3)] = '0;
			pending_quats.push_back(x);
		end
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				quat_t sent;
				sent.q[0] = scalar_in;
				sent.q[1] = vec_x_in;
				sent.q[2] = vec_y_in;
				sent.q[3] = vec_z_in;
				expected_units.push_back(normalize_quat(sent));
			end
			if (!(start && busy)) begin
				if (gap_left > 0 || pending_quats.size() == 0) begin
					start <= 1'b0;
					if (gap_left > 0) gap_left <= gap_left - 1;
					else stimulus_done <= 1'b1;
				end else begin
					quat_t nx;
					nx = pending_quats.pop_front();
					start <= 1'b1;
					scalar_in <= nx.q[0];
					vec_x_in <= nx.q[1];
					vec_y_in <= nx.q[2];
					vec_z_in <= nx.q[3];
					gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			unit_quat_t e;
			if (expected_units.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat");
			end else begin
				e = expected_units.pop_front();
				if (scalar_out !== e.part[0] || vec_x_out !== e.part[1] ||
						vec_y_out !== e.part[2] || vec_z_out !== e.part[3] ||
						magnitude !== e.mag || zero_length !== e.zero) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %h %h %h %h %h %b got %h %h %h %h %h %b",
							e.part[0], e.part[1], e.part[2], e.part[3], e.mag, e.zero,
							scalar_out, vec_x_out, vec_y_out, vec_z_out, magnitude,
							zero_length);
				end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (stimulus_done && expected_units.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_units.size() == 0)
			$display("quaternion_normalize_tb: clean");
		else
			$display("quaternion_normalize_tb: errors");
		$finish;
	end

	initial begin
		#1000000;
		$display("quaternion_normalize_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
